// ----- design/ddhs_pkg.sv -----
// Package for the differential-drive speed and heading controller.
// Holds the fixed-point constants, the register index codes and small helper functions.
// It has no dependencies.
package ddhs_pkg;

  localparam int HEADING_BITS = 24;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 31;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 28;

  typedef logic [HEADING_BITS-1:0] heading_t;
  typedef logic [PROD_W-1:0]       prod_t;

  // 1/(4*pi) as Q0.32, split so that each partial product stays narrow.
  localparam longint INV_4PI_Q32 = 64'd341782638;
  localparam logic [MUL_B_W-1:0] INV_LO = MUL_B_W'(INV_4PI_Q32 % 32768);
  localparam logic [MUL_B_W-1:0] INV_HI = MUL_B_W'(INV_4PI_Q32 / 32768);
  localparam int INV_SPLIT = 15;

  // 2*pi as Q3.28.
  localparam logic [MUL_B_W-1:0] TWO_PI_Q28 = 31'd1686629713;

  // One turn split as 180 * ANG_Q0 + ANG_R0, so that the angle target needs only a
  // narrow division by 180.
  localparam longint TURN   = 64'd1 << HEADING_BITS;
  localparam logic [MUL_B_W-1:0] ANG_Q0 = MUL_B_W'(TURN / 180);
  localparam logic [MUL_B_W-1:0] ANG_R0 = MUL_B_W'(TURN % 180);

  // Reciprocals for division by multiplication; the estimate is at most one low.
  localparam int RECIP_180_SHIFT = 24;
  localparam logic [MUL_B_W-1:0] RECIP_180 = MUL_B_W'((64'd1 << RECIP_180_SHIFT) / 180);
  localparam int RECIP_100_SHIFT = 30;
  localparam logic [MUL_B_W-1:0] RECIP_100 = MUL_B_W'((64'd1 << RECIP_100_SHIFT) / 100);

  localparam logic [MUL_B_W-1:0] DIV_180    = 31'd180;
  localparam logic [MUL_B_W-1:0] DIV_100    = 31'd100;
  localparam logic [MUL_B_W-1:0] DUTY_SCALE = 31'd10000;

  localparam int Q_ONE     = 16384;
  localparam int DEAD_BAND = 819;
  localparam int DUTY_MAX  = 9900;

  localparam int DELTA_SHIFT = 56 - HEADING_BITS;
  localparam int ERR_SHIFT   = HEADING_BITS + 14;

  localparam logic [2:0] REG_SPEED_MAX   = 3'd0;
  localparam logic [2:0] REG_ANGLE_MAX   = 3'd1;
  localparam logic [2:0] REG_YAW_GAIN    = 3'd2;
  localparam logic [2:0] REG_STEP_TIME   = 3'd3;
  localparam logic [2:0] REG_GAIN_SPD_FB = 3'd4;
  localparam logic [2:0] REG_GAIN_SPD_CM = 3'd5;
  localparam logic [2:0] REG_GAIN_HEAD   = 3'd6;
  localparam logic [2:0] REG_GAIN_YAW    = 3'd7;

  localparam logic       ACT_COMMAND  = 1'b0;
  localparam logic       ACT_TICK     = 1'b1;
  localparam logic [1:0] MODE_RUN     = 2'd0;
  localparam logic [1:0] MODE_NEUTRAL = 2'd1;
  localparam logic [1:0] MODE_BRAKE   = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  // Round to nearest, ties away from zero, on a magnitude.
  function automatic prod_t round_shift(input prod_t p, input int s);
    return (p + (prod_t'(1) << (s - 1))) >> s;
  endfunction

  function automatic logic signed [ACC_W-1:0] with_sign(input logic [ACC_W-1:0] m,
                                                        input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

endpackage

// ----- design/diff_drive_heading_speed_control.sv -----
// Differential-drive speed and heading controller: one shared 34x31 multiplier under
// a step sequencer. Depends on ddhs_pkg.
// A rejected or repeated-speed command, and a neutral or brake tick, go from the request
// straight to the output step; a new speed command first passes SP_MUL, SP_Q1 and SP_SET.
// A run tick passes the 15 products one after another through the shared multiplier. One
// request is in work at a time; the output register frees the input side once the
// result is loaded. Reset (rst, synchronous) restores the register defaults and clears
// heading, yaw rate and the targets.
module diff_drive_heading_speed_control import ddhs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // speed_code[7:0], angle_code[15:8], run_mode[17:16], measured_left[33:18],
  // measured_right[49:34], zero fill
  input  logic [55:0] s_tdata,
  // action
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // command_status[0], duty_left[14:1], duty_right[28:15], left_dir_a[29],
  // left_dir_b[30], right_dir_a[31], right_dir_b[32], zero fill
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_YAW_MUL  = 5'd1;
  localparam logic [4:0] ST_YAW_SET  = 5'd2;
  localparam logic [4:0] ST_HD_MUL   = 5'd3;
  localparam logic [4:0] ST_HD_LO    = 5'd4;
  localparam logic [4:0] ST_HD_HI    = 5'd5;
  localparam logic [4:0] ST_HD_ADD   = 5'd6;
  localparam logic [4:0] ST_TG_Q     = 5'd7;
  localparam logic [4:0] ST_TG_X     = 5'd8;
  localparam logic [4:0] ST_TG_Q1    = 5'd9;
  localparam logic [4:0] ST_TG_SET   = 5'd10;
  localparam logic [4:0] ST_ERR_MUL  = 5'd11;
  localparam logic [4:0] ST_ERR_SET  = 5'd12;
  localparam logic [4:0] ST_UT_A     = 5'd13;
  localparam logic [4:0] ST_UT_B     = 5'd14;
  localparam logic [4:0] ST_UA_A     = 5'd15;
  localparam logic [4:0] ST_UA_B     = 5'd16;
  localparam logic [4:0] ST_MIX      = 5'd17;
  localparam logic [4:0] ST_DUTY_L   = 5'd18;
  localparam logic [4:0] ST_DUTY_R   = 5'd19;
  localparam logic [4:0] ST_DUTY_SET = 5'd20;
  localparam logic [4:0] ST_SP_MUL   = 5'd21;
  localparam logic [4:0] ST_SP_Q1    = 5'd22;
  localparam logic [4:0] ST_SP_SET   = 5'd23;
  localparam logic [4:0] ST_FIN      = 5'd24;

  logic [4:0] step;

  logic [7:0]  speed_max, angle_max;
  logic [15:0] yaw_gain, step_time, gain_fb, gain_cmd, gain_head, gain_yaw;

  logic [7:0]               last_speed;
  logic signed [15:0]       desired_speed;
  logic [7:0]               desired_angle;
  heading_t                 heading;
  logic signed [15:0]       yaw_rate;

  logic signed [15:0] vl, vr, w_cur;
  logic [21:0]        sx;
  logic               sneg, hneg, eneg, er_neg;
  logic [15:0]        sq1;
  logic [32:0]        mreg;
  logic [63:0]        acc;
  heading_t           tq, target;
  logic [15:0]        xr;
  logic [8:0]         q1a;
  logic [16:0]        er_mag;
  logic signed [ACC_W-1:0] t1, ut, a1, ua, dl, dr;

  logic        res_status;
  logic [13:0] res_dl, res_dr;
  logic [3:0]  res_dirs;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  prod_t              prod;

  logic [7:0]         in_scode, in_acode, scode_dist;
  logic [1:0]         in_mode;
  logic signed [15:0] in_left, in_right;
  logic signed [16:0] ydiff, wsum, vsum;
  heading_t           diff, err_mag;
  logic [63:0]        total;
  prod_t              r15, r12, r13, r6, r_err, r_delta, r_duty;
  logic [15:0]        tg_r;
  logic [8:0]         tg_q;
  logic [21:0]        sp_r;
  logic [15:0]        sp_q;
  logic signed [ACC_W-1:0] ua_raw, ut_c, lim;
  logic [ACC_W-1:0]   ua_mag;
  logic [15:0]        wm;

  function automatic logic signed [15:0] clamp_one(input logic signed [15:0] v);
    if (v < -16'sd16384) return -16'sd16384;
    else if (v > 16'sd16384) return 16'sd16384;
    else return v;
  endfunction

  assign in_scode   = s_tdata[7:0];
  assign in_acode   = s_tdata[15:8];
  assign in_mode    = s_tdata[17:16];
  assign in_left    = $signed(s_tdata[33:18]);
  assign in_right   = $signed(s_tdata[49:34]);
  assign scode_dist = (in_scode < 8'd100) ? 8'd100 - in_scode : in_scode - 8'd100;

  assign s_tready = (step == ST_IDLE);

  assign ydiff = 17'(vr) - 17'(vl);
  assign wsum  = 17'(w_cur) + 17'(yaw_rate);
  assign vsum  = 17'(vl) + 17'(vr);
  assign diff  = target - heading;
  assign err_mag = diff[HEADING_BITS-1] ? heading_t'(-diff) : diff;
  assign total = acc + (prod[63:0] << INV_SPLIT);

  always_comb begin
    r15     = round_shift(prod, 15);
    r12     = round_shift(prod, 12);
    r13     = round_shift(prod, 13);
    r6      = round_shift(prod, 6);
    r_err   = round_shift(prod, ERR_SHIFT);
    r_delta = round_shift(prod_t'(total), DELTA_SHIFT);
    r_duty  = prod >> 14;
    wm      = (r15 > prod_t'(32767)) ? 16'd32768 : r15[15:0];
    tg_r    = xr - prod[15:0];
    tg_q    = q1a + 9'(tg_r >= 16'd180);
    sp_r    = sx - prod[21:0];
    sp_q    = sq1 + 16'(sp_r >= 22'd100);
    ua_raw  = a1 - with_sign(r6[ACC_W-1:0], w_cur[15]);
    ua_mag  = abs_acc(ua_raw);
    lim     = ACC_W'(Q_ONE) - $signed(abs_acc(ua));
    if (ut > lim) ut_c = lim;
    else if (ut < -lim) ut_c = -lim;
    else ut_c = ut;
  end

  // Operand selection for the shared multiplier; each product is used one step later.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      ST_YAW_MUL: begin
        mul_a = MUL_A_W'(ydiff[16] ? -ydiff : ydiff);
        mul_b = MUL_B_W'(yaw_gain);
      end
      ST_HD_MUL: begin
        // The sum of two saturated rates can reach -65536, whose magnitude needs all 17 bits.
        mul_a = MUL_A_W'($unsigned(wsum[16] ? -wsum : wsum));
        mul_b = MUL_B_W'(step_time);
      end
      ST_HD_LO: begin
        mul_a = MUL_A_W'(prod[32:0]);
        mul_b = INV_LO;
      end
      ST_HD_HI: begin
        mul_a = MUL_A_W'(mreg);
        mul_b = INV_HI;
      end
      ST_HD_ADD: begin
        mul_a = MUL_A_W'(desired_angle);
        mul_b = ANG_Q0;
      end
      ST_TG_Q: begin
        mul_a = MUL_A_W'(desired_angle);
        mul_b = ANG_R0;
      end
      ST_TG_X: begin
        mul_a = MUL_A_W'(prod[15:0] + 16'd90);
        mul_b = RECIP_180;
      end
      ST_TG_Q1: begin
        mul_a = MUL_A_W'(prod[32:RECIP_180_SHIFT]);
        mul_b = DIV_180;
      end
      ST_ERR_MUL: begin
        mul_a = MUL_A_W'(err_mag);
        mul_b = TWO_PI_Q28;
      end
      ST_ERR_SET: begin
        mul_a = MUL_A_W'(desired_speed[15] ? -desired_speed : desired_speed);
        mul_b = MUL_B_W'(gain_cmd);
      end
      ST_UT_A: begin
        mul_a = MUL_A_W'(vsum[16] ? -vsum : vsum);
        mul_b = MUL_B_W'(gain_fb);
      end
      ST_UT_B: begin
        mul_a = MUL_A_W'(er_mag);
        mul_b = MUL_B_W'(gain_head);
      end
      ST_UA_A: begin
        mul_a = MUL_A_W'(w_cur[15] ? -17'(w_cur) : 17'(w_cur));
        mul_b = MUL_B_W'(gain_yaw);
      end
      ST_DUTY_L: begin
        mul_a = MUL_A_W'(abs_acc(dl));
        mul_b = DUTY_SCALE;
      end
      ST_DUTY_R: begin
        mul_a = MUL_A_W'(abs_acc(dr));
        mul_b = DUTY_SCALE;
      end
      ST_SP_MUL: begin
        mul_a = MUL_A_W'(sx);
        mul_b = RECIP_100;
      end
      ST_SP_Q1: begin
        mul_a = MUL_A_W'(prod[45:RECIP_100_SHIFT]);
        mul_b = DIV_100;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_max <= 8'd200;
      angle_max <= 8'd180;
      yaw_gain  <= 16'd8192;
      step_time <= 16'd655;
      gain_fb   <= 16'd4096;
      gain_cmd  <= 16'd4096;
      gain_head <= 16'd4096;
      gain_yaw  <= 16'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPEED_MAX:   speed_max <= cfg_data[7:0];
        REG_ANGLE_MAX:   angle_max <= cfg_data[7:0];
        REG_YAW_GAIN:    yaw_gain  <= cfg_data;
        REG_STEP_TIME:   step_time <= cfg_data;
        REG_GAIN_SPD_FB: gain_fb   <= cfg_data;
        REG_GAIN_SPD_CM: gain_cmd  <= cfg_data;
        REG_GAIN_HEAD:   gain_head <= cfg_data;
        REG_GAIN_YAW:    gain_yaw  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= ST_IDLE;
      m_tvalid      <= 1'b0;
      last_speed    <= '0;
      desired_speed <= '0;
      desired_angle <= '0;
      heading       <= '0;
      yaw_rate      <= '0;
    end else begin
      if (m_tvalid && m_tready && step != ST_FIN) m_tvalid <= 1'b0;
      unique case (step)
        ST_IDLE: begin
          if (s_tvalid) begin
            res_dl <= '0;
            res_dr <= '0;
            if (s_tuser == ACT_COMMAND) begin
              res_dirs <= '0;
              if (in_scode > speed_max || in_acode > angle_max) begin
                res_status <= 1'b1;
                step       <= ST_FIN;
              end else begin
                res_status    <= 1'b0;
                desired_angle <= in_acode;
                last_speed    <= in_scode;
                sneg          <= in_scode < 8'd100;
                sx            <= {scode_dist, 14'd0} + 22'd50;
                step          <= (in_scode != last_speed) ? ST_SP_MUL : ST_FIN;
              end
            end else if (in_mode == MODE_RUN) begin
              res_status <= 1'b0;
              res_dirs   <= '0;
              vl         <= clamp_one(in_left);
              vr         <= clamp_one(in_right);
              step       <= ST_YAW_MUL;
            end else begin
              // Brake, and the unused mode code, hold both bridges shorted.
              res_status <= 1'b0;
              res_dirs   <= (in_mode == MODE_NEUTRAL) ? 4'b0000 : 4'b1111;
              step       <= ST_FIN;
            end
          end
        end
        ST_YAW_MUL: step <= ST_YAW_SET;
        ST_YAW_SET: begin
          if (ydiff[16]) w_cur <= $signed(-wm);
          else w_cur <= (wm > 16'd32767) ? 16'sd32767 : $signed(wm);
          step <= ST_HD_MUL;
        end
        ST_HD_MUL: begin
          yaw_rate <= w_cur;
          hneg     <= wsum[16];
          step     <= ST_HD_LO;
        end
        ST_HD_LO: begin
          mreg <= prod[32:0];
          step <= ST_HD_HI;
        end
        ST_HD_HI: begin
          acc  <= prod[63:0];
          step <= ST_HD_ADD;
        end
        ST_HD_ADD: begin
          heading <= hneg ? heading - r_delta[HEADING_BITS-1:0]
                          : heading + r_delta[HEADING_BITS-1:0];
          step    <= ST_TG_Q;
        end
        ST_TG_Q: begin
          tq   <= prod[HEADING_BITS-1:0];
          step <= ST_TG_X;
        end
        ST_TG_X: begin
          xr   <= prod[15:0] + 16'd90;
          step <= ST_TG_Q1;
        end
        ST_TG_Q1: begin
          q1a  <= prod[32:RECIP_180_SHIFT];
          step <= ST_TG_SET;
        end
        ST_TG_SET: begin
          target <= tq + heading_t'(tg_q);
          step   <= ST_ERR_MUL;
        end
        ST_ERR_MUL: begin
          // An error of exactly half a turn has its top bit set and so counts as negative.
          eneg <= diff[HEADING_BITS-1];
          step <= ST_ERR_SET;
        end
        ST_ERR_SET: begin
          er_mag <= r_err[16:0];
          er_neg <= eneg;
          step   <= ST_UT_A;
        end
        ST_UT_A: begin
          t1   <= with_sign(r12[ACC_W-1:0], desired_speed[15]);
          step <= ST_UT_B;
        end
        ST_UT_B: begin
          ut   <= t1 - with_sign(r13[ACC_W-1:0], vsum[16]);
          step <= ST_UA_A;
        end
        ST_UA_A: begin
          a1   <= with_sign(r12[ACC_W-1:0], er_neg);
          step <= ST_UA_B;
        end
        ST_UA_B: begin
          if (ua_mag > ACC_W'(Q_ONE)) ua <= with_sign(ACC_W'(Q_ONE), ua_raw[ACC_W-1]);
          else if (ua_mag <= ACC_W'(DEAD_BAND)) ua <= '0;
          else ua <= ua_raw;
          step <= ST_MIX;
        end
        ST_MIX: begin
          dl   <= ut_c - ua;
          dr   <= ut_c + ua;
          step <= ST_DUTY_L;
        end
        ST_DUTY_L: step <= ST_DUTY_R;
        ST_DUTY_R: begin
          res_dl      <= (r_duty > prod_t'(DUTY_MAX)) ? 14'(DUTY_MAX) : r_duty[13:0];
          res_dirs[0] <= ~dl[ACC_W-1];
          res_dirs[1] <= dl[ACC_W-1];
          step        <= ST_DUTY_SET;
        end
        ST_DUTY_SET: begin
          res_dr      <= (r_duty > prod_t'(DUTY_MAX)) ? 14'(DUTY_MAX) : r_duty[13:0];
          res_dirs[2] <= ~dr[ACC_W-1];
          res_dirs[3] <= dr[ACC_W-1];
          step        <= ST_FIN;
        end
        ST_SP_MUL: step <= ST_SP_Q1;
        ST_SP_Q1: begin
          sq1  <= prod[45:RECIP_100_SHIFT];
          step <= ST_SP_SET;
        end
        ST_SP_SET: begin
          desired_speed <= sneg ? $signed(-sp_q) : $signed(sp_q);
          step          <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, res_dirs, res_dr, res_dl, res_status};
            step     <= ST_IDLE;
          end
        end
        default: step <= ST_IDLE;
      endcase
    end
  end

endmodule
